### src/mic_source_selector_defines.svh
// assertion macros for the microphone source selector
`ifndef MIC_SOURCE_SELECTOR_DEFINES_SVH
`define MIC_SOURCE_SELECTOR_DEFINES_SVH

// concurrent check, masked while reset is low
`define MSS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mic_source_selector check failed");

// concurrent check that also holds during reset
`define MSS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mic_source_selector check failed");

`endif

### src/mss_pkg.sv
// types, register map and codes shared by the microphone source selector
`timescale 1ns / 1ps

package mss_pkg;

    localparam int LEVEL_W    = 16;
    localparam int RATIO_W    = 8;
    localparam int STREAK_W   = 8;
    localparam int TIME_W     = 32;
    localparam int CODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = LEVEL_W + RATIO_W;
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAPEL_FITTED        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAPEL_PRESENT_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAPEL_HOLD_MS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LEVEL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_NUMERATOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_DENOMINATOR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_BLOCKS       = 3'd6;

    // register reset values
    localparam logic                 RST_LAPEL_FITTED        = 1'b1;
    localparam logic [LEVEL_W-1:0]   RST_LAPEL_PRESENT_LEVEL = 16'd200;
    localparam logic [LEVEL_W-1:0]   RST_LAPEL_HOLD_MS       = 16'd2000;
    localparam logic [LEVEL_W-1:0]   RST_SILENCE_LEVEL       = 16'd300;
    localparam logic [RATIO_W-1:0]   RST_RATIO_NUMERATOR     = 8'd3;
    localparam logic [RATIO_W-1:0]   RST_RATIO_DENOMINATOR   = 8'd2;
    localparam logic [STREAK_W-1:0]  RST_SWITCH_BLOCKS       = 8'd3;

    // case mic codes
    localparam logic [CODE_W-1:0] CASE_A = 2'd0;
    localparam logic [CODE_W-1:0] CASE_B = 2'd1;
    localparam logic [CODE_W-1:0] CASE_C = 2'd2;

    // source codes
    localparam logic [CODE_W-1:0] SOURCE_LAPEL = 2'd3;

    localparam logic [STREAK_W-1:0] STREAK_MAX = {STREAK_W{1'b1}};

    typedef struct packed {
        logic                lapel_fitted;
        logic [LEVEL_W-1:0]  lapel_present_level;
        logic [LEVEL_W-1:0]  lapel_hold_ms;
        logic [LEVEL_W-1:0]  silence_level;
        logic [RATIO_W-1:0]  ratio_numerator;
        logic [RATIO_W-1:0]  ratio_denominator;
        logic [STREAK_W-1:0] switch_blocks;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0]   incumbent_case;
        logic [CODE_W-1:0]   challenger_case;
        logic [STREAK_W-1:0] challenger_streak;
        logic [TIME_W-1:0]   lapel_hold_deadline;
    } state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_a;
        logic [LEVEL_W-1:0] level_b;
        logic [LEVEL_W-1:0] level_c;
        logic [LEVEL_W-1:0] level_lapel;
        logic               bus_two_valid;
        logic [TIME_W-1:0]  time_ms;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] source;
        logic              lapel_selected;
        logic [CODE_W-1:0] case_choice;
    } result_t;

endpackage

### src/mss_cfg_regs.sv
// configuration register file of the microphone source selector
`timescale 1ns / 1ps

module mss_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_data,
    output mss_pkg::cfg_t                  cfg
);

    mss_pkg::cfg_t cfg_reg;
    mss_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mss_pkg::REG_LAPEL_FITTED:
                    cfg_next.lapel_fitted = cfg_data[0];
                mss_pkg::REG_LAPEL_PRESENT_LEVEL:
                    cfg_next.lapel_present_level = cfg_data[mss_pkg::LEVEL_W-1:0];
                mss_pkg::REG_LAPEL_HOLD_MS:
                    cfg_next.lapel_hold_ms = cfg_data[mss_pkg::LEVEL_W-1:0];
                mss_pkg::REG_SILENCE_LEVEL:
                    cfg_next.silence_level = cfg_data[mss_pkg::LEVEL_W-1:0];
                mss_pkg::REG_RATIO_NUMERATOR:
                    cfg_next.ratio_numerator = cfg_data[mss_pkg::RATIO_W-1:0];
                mss_pkg::REG_RATIO_DENOMINATOR:
                    cfg_next.ratio_denominator = cfg_data[mss_pkg::RATIO_W-1:0];
                mss_pkg::REG_SWITCH_BLOCKS:
                    cfg_next.switch_blocks = cfg_data[mss_pkg::STREAK_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lapel_fitted        <= mss_pkg::RST_LAPEL_FITTED;
            cfg_reg.lapel_present_level <= mss_pkg::RST_LAPEL_PRESENT_LEVEL;
            cfg_reg.lapel_hold_ms       <= mss_pkg::RST_LAPEL_HOLD_MS;
            cfg_reg.silence_level       <= mss_pkg::RST_SILENCE_LEVEL;
            cfg_reg.ratio_numerator     <= mss_pkg::RST_RATIO_NUMERATOR;
            cfg_reg.ratio_denominator   <= mss_pkg::RST_RATIO_DENOMINATOR;
            cfg_reg.switch_blocks       <= mss_pkg::RST_SWITCH_BLOCKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/mss_decide.sv
// per-block source decision and next selector state
`timescale 1ns / 1ps

module mss_decide
(
    input  mss_pkg::cfg_t    cfg,
    input  mss_pkg::state_t  state,
    input  mss_pkg::item_t   item,
    output mss_pkg::state_t  state_next,
    output mss_pkg::result_t result
);

    logic                                bus_ok;
    logic [mss_pkg::LEVEL_W-1:0]         lvl_c;
    logic [mss_pkg::LEVEL_W-1:0]         lvl_lapel;
    logic                                rearm;
    logic [mss_pkg::TIME_W-1:0]          deadline;
    logic [mss_pkg::TIME_W-1:0]          diff;
    logic                                hold_active;
    logic                                c_dropped;
    logic [mss_pkg::CODE_W-1:0]          inc_mid;
    logic [mss_pkg::STREAK_W-1:0]        streak_mid;
    logic [mss_pkg::CODE_W-1:0]          best_ab;
    logic [mss_pkg::LEVEL_W-1:0]         lvl_ab;
    logic [mss_pkg::CODE_W-1:0]          best;
    logic [mss_pkg::LEVEL_W-1:0]         lvl_best;
    logic [mss_pkg::LEVEL_W-1:0]         lvl_inc;
    logic                                quiet;
    logic [mss_pkg::PROD_W-1:0]          prod_best;
    logic [mss_pkg::PROD_W-1:0]          prod_inc;
    logic                                qualify;
    logic [mss_pkg::STREAK_W-1:0]        streak_inc;

    assign bus_ok    = item.bus_two_valid;
    assign lvl_c     = bus_ok ? item.level_c : '0;
    assign lvl_lapel = bus_ok ? item.level_lapel : '0;

    // lapel hold, wrapping signed compare against the deadline
    assign rearm    = cfg.lapel_fitted && bus_ok && (lvl_lapel > cfg.lapel_present_level);
    assign deadline = rearm
                    ? item.time_ms + {{(mss_pkg::TIME_W-mss_pkg::LEVEL_W){1'b0}}, cfg.lapel_hold_ms}
                    : state.lapel_hold_deadline;
    assign diff        = item.time_ms - deadline;
    assign hold_active = cfg.lapel_fitted && bus_ok && diff[mss_pkg::TIME_W-1];

    // incumbent C falls back to the louder of A and B when bus two drops
    assign c_dropped = !bus_ok && (state.incumbent_case == mss_pkg::CASE_C);

    always_comb
    begin
        if (c_dropped)
            inc_mid = (item.level_b > item.level_a) ? mss_pkg::CASE_B : mss_pkg::CASE_A;
        else if (state.incumbent_case > mss_pkg::CASE_C)
            inc_mid = mss_pkg::CASE_A;
        else
            inc_mid = state.incumbent_case;
    end

    assign streak_mid = c_dropped ? '0 : state.challenger_streak;

    // loudest case mic, earliest wins ties
    assign best_ab  = (item.level_b > item.level_a) ? mss_pkg::CASE_B : mss_pkg::CASE_A;
    assign lvl_ab   = (item.level_b > item.level_a) ? item.level_b : item.level_a;
    assign best     = (bus_ok && (lvl_c > lvl_ab)) ? mss_pkg::CASE_C : best_ab;
    assign lvl_best = (bus_ok && (lvl_c > lvl_ab)) ? lvl_c : lvl_ab;

    always_comb
    begin
        case (inc_mid)
            mss_pkg::CASE_B: lvl_inc = item.level_b;
            mss_pkg::CASE_C: lvl_inc = lvl_c;
            default:         lvl_inc = item.level_a;
        endcase
    end

    assign quiet = (item.level_a <= cfg.silence_level)
                && (item.level_b <= cfg.silence_level)
                && (!bus_ok || (lvl_c <= cfg.silence_level));

    assign prod_best = mss_pkg::PROD_W'(lvl_best) * mss_pkg::PROD_W'(cfg.ratio_denominator);
    assign prod_inc  = mss_pkg::PROD_W'(lvl_inc) * mss_pkg::PROD_W'(cfg.ratio_numerator);

    assign qualify = (best != inc_mid) && quiet && (prod_best > prod_inc);

    always_comb
    begin
        state_next.lapel_hold_deadline = deadline;
        state_next.incumbent_case      = inc_mid;
        state_next.challenger_case     = state.challenger_case;
        state_next.challenger_streak   = '0;
        streak_inc                     = '0;
        if (qualify)
        begin
            if (best == state.challenger_case)
                streak_inc = (streak_mid < mss_pkg::STREAK_MAX) ? streak_mid + 1'b1 : streak_mid;
            else
                streak_inc = mss_pkg::STREAK_W'(1);
            state_next.challenger_case = best;
            if (streak_inc >= cfg.switch_blocks)
            begin
                state_next.incumbent_case    = best;
                state_next.challenger_streak = '0;
            end
            else
            begin
                state_next.challenger_streak = streak_inc;
            end
        end
    end

    assign result.source         = hold_active ? mss_pkg::SOURCE_LAPEL
                                               : state_next.incumbent_case;
    assign result.lapel_selected = hold_active;
    assign result.case_choice    = state_next.incumbent_case;

endmodule

### src/mic_source_selector.sv
// top level of the microphone source selector
`timescale 1ns / 1ps
`include "mic_source_selector_defines.svh"

// Takes one item per audio block and returns one result per item. An item
// passes through an input register, combinational decision logic and a result
// register, so a new item is taken every clock cycle while the result is not
// stalled; the rate is set by the decision logic that updates the selector
// state between the two registers. A stalled result holds its register while
// one more item waits in the input register. Configuration writes take effect
// at the next clock edge and belong in idle periods. No memory is used, so
// there is no start-up sweep after reset.
module mic_source_selector
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // level_a, level_b, level_c, level_lapel, time_ms
    input  logic [mss_pkg::IN_DATA_W-1:0]   s_tdata,
    // bus_two_valid
    input  logic [mss_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // source, lapel_selected, case_choice, zero fill
    output logic [mss_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [mss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mss_pkg::cfg_t    cfg;
    mss_pkg::item_t   item_reg;
    mss_pkg::item_t   item_next;
    logic             in_valid_reg;
    mss_pkg::state_t  state_reg;
    mss_pkg::state_t  state_next;
    mss_pkg::result_t result_next;
    mss_pkg::result_t result_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             s_xfer;

    mss_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mss_decide u_decide
    (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb
    begin
        item_next.level_a       = s_tdata[15:0];
        item_next.level_b       = s_tdata[31:16];
        item_next.level_c       = s_tdata[47:32];
        item_next.level_lapel   = s_tdata[63:48];
        item_next.time_ms       = s_tdata[95:64];
        item_next.bus_two_valid = s_tuser[0];
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
            item_reg <= item_next;
    end

    // selector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.incumbent_case      <= mss_pkg::CASE_A;
            state_reg.challenger_case     <= mss_pkg::CASE_A;
            state_reg.challenger_streak   <= '0;
            state_reg.lapel_hold_deadline <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, result_reg.case_choice, result_reg.lapel_selected,
                       result_reg.source};

    `MSS_ASSERT(a_advance_fills_output, clk, rst_n, advance |=> m_tvalid)
    `MSS_ASSERT(a_state_only_on_advance, clk, rst_n, !advance |=> $stable(state_reg))
    `MSS_ASSERT(a_held_item_kept, clk, rst_n, (in_valid_reg && !advance) |=> in_valid_reg)
    `MSS_ASSERT(a_lapel_means_source, clk, rst_n,
        m_tvalid |-> (!result_reg.lapel_selected || (result_reg.source == mss_pkg::SOURCE_LAPEL)))

endmodule
